// File: design/slbm_pkg.sv
// Shared types, codes and constants of the serial-loaded bank mapper.
`default_nettype none
package slbm_pkg;

    // Work RAM window and default size
    localparam int unsigned RAM_BYTES_DEF = 8192;
    localparam int unsigned WIN_AW        = 13;

    // Access kinds
    localparam logic [1:0] FUNC_CPU_RD = 2'd0;
    localparam logic [1:0] FUNC_CPU_WR = 2'd1;
    localparam logic [1:0] FUNC_PPU_RD = 2'd2;
    localparam logic [1:0] FUNC_PPU_WR = 2'd3;

    // Result targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_WRAM = 2'd1;
    localparam logic [1:0] TGT_PRG  = 2'd2;
    localparam logic [1:0] TGT_CHR  = 2'd3;

    // Configuration register indexes (word address)
    localparam logic CFG_PRG_BANKS = 1'b0;
    localparam logic CFG_CHR_BYTES = 1'b1;

    // Mapper register select, address bits 14:13
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    // Reset values
    localparam logic [4:0]  SHIFT_EMPTY   = 5'b10000;
    localparam logic [4:0]  CONTROL_RST   = 5'h0C;
    localparam logic [5:0]  PRG_BANKS_RST = 6'd2;
    localparam logic [17:0] CHR_BYTES_RST = 18'd8192;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } slbm_in_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mapped_address;
        logic [7:0]  ram_read_data;
        logic        chr_in_range;
        logic [1:0]  mirror_mode;
    } slbm_out_t;

    typedef struct packed {
        logic [5:0]  prg_banks;
        logic [17:0] chr_bytes;
    } slbm_cfg_t;

    // Mapping result held in the output register; ram data joins it there
    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mapped_address;
        logic        chr_in_range;
        logic [1:0]  mirror_mode;
        logic        ram_rd;
    } slbm_res_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [WIN_AW-1:0] addr;
        logic [7:0]        data;
    } slbm_wram_req_t;

endpackage
`default_nettype wire

// File: design/slbm_cfg.sv
// APB configuration registers: program bank count and pattern memory size.
`default_nettype none
module slbm_cfg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output slbm_pkg::slbm_cfg_t     cfg
);
    import slbm_pkg::*;

    logic [5:0]  prg_banks_reg;
    logic [17:0] chr_bytes_reg;
    logic        wr_strobe;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_banks_reg <= PRG_BANKS_RST;
            chr_bytes_reg <= CHR_BYTES_RST;
        end else if (wr_strobe) begin
            unique case (paddr[2])
                CFG_PRG_BANKS: prg_banks_reg <= pwdata[5:0];
                CFG_CHR_BYTES: chr_bytes_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            CFG_PRG_BANKS: prdata = {26'd0, prg_banks_reg};
            CFG_CHR_BYTES: prdata = {14'd0, chr_bytes_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.prg_banks = prg_banks_reg;
    assign cfg.chr_bytes = chr_bytes_reg;

endmodule
`default_nettype wire

// File: design/slbm_wram.sv
// Work RAM with a clearing sweep after reset and a registered read port.
`default_nettype none
module slbm_wram #(
    parameter int unsigned RAM_BYTES = slbm_pkg::RAM_BYTES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire slbm_pkg::slbm_wram_req_t req,
    output logic [7:0]                  rd_data,
    output logic                        busy
);
    import slbm_pkg::*;

    localparam int unsigned AW = $clog2(RAM_BYTES);
    localparam logic [AW-1:0] LAST = AW'(RAM_BYTES - 1);

    logic [7:0]    mem [RAM_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clr_active_reg;
    logic          clr_active_next;

    // Clearing sweep, one entry per cycle
    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg) begin
            if (clr_cnt_reg == LAST) begin
                clr_active_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            clr_active_reg <= 1'b1;
        end else begin
            clr_cnt_reg    <= clr_cnt_next;
            clr_active_reg <= clr_active_next;
        end
    end

    // Storage: sweep writes zeros, otherwise one access per transaction
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_cnt_reg] <= 8'd0;
        end else if (req.wr_en) begin
            mem[req.addr[AW-1:0]] <= req.data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule
`default_nettype wire

// File: design/slbm_core.sv
// Mapper registers, serial loader and address banking for one transaction.
`default_nettype none
module slbm_core #(
    parameter int unsigned RAM_BYTES = slbm_pkg::RAM_BYTES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step,
    input  wire slbm_pkg::slbm_in_t       item,
    input  wire slbm_pkg::slbm_cfg_t      cfg,
    output slbm_pkg::slbm_res_t           res,
    output slbm_pkg::slbm_wram_req_t      wreq
);
    import slbm_pkg::*;

    localparam logic [15:0] RB1 = 16'(RAM_BYTES);
    localparam logic [15:0] RB2 = 16'(RAM_BYTES * 2);
    localparam logic [15:0] RB4 = 16'(RAM_BYTES * 4);

    logic [4:0] shift_reg, shift_next;
    logic [4:0] control_reg, control_next;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic [4:0] prg_bank_reg, prg_bank_next;

    logic [15:0] a;
    logic        is_cpu;
    logic        in_wram;
    logic        in_rom;
    logic        in_chr;
    logic [15:0] wrem;
    logic [3:0]  bank4;
    logic [4:0]  last_bank;
    logic [5:0]  banks_m1;
    logic [18:0] prg_off;
    logic [18:0] chr_off;
    logic [4:0]  shifted;

    assign a       = item.bus_address;
    assign is_cpu  = (item.func == FUNC_CPU_RD) || (item.func == FUNC_CPU_WR);
    assign in_wram = is_cpu && (a[15:13] == 3'b011);
    assign in_rom  = is_cpu && a[15];
    assign in_chr  = !is_cpu && (a[15:13] == 3'b000);

    // Window offset modulo RAM size; quotient is at most seven
    always_comb begin
        wrem = {3'd0, a[12:0]};
        if (wrem >= RB4) wrem = wrem - RB4;
        if (wrem >= RB2) wrem = wrem - RB2;
        if (wrem >= RB1) wrem = wrem - RB1;
    end

    // Program ROM banking
    assign bank4     = prg_bank_reg[3:0];
    assign banks_m1  = cfg.prg_banks - 6'd1;
    assign last_bank = banks_m1[4:0];

    always_comb begin
        case (control_reg[3:2])
            2'd0, 2'd1: prg_off = {1'b0, bank4[3:1], a[14:0]};
            2'd2:       prg_off = a[14] ? {1'b0, bank4, a[13:0]} : {5'd0, a[13:0]};
            default:    prg_off = a[14] ? {last_bank, a[13:0]} : {1'b0, bank4, a[13:0]};
        endcase
    end

    // Pattern memory banking, 8K or two 4K windows
    always_comb begin
        if (!control_reg[4]) begin
            chr_off = {2'd0, chr_low_reg[4:1], a[12:0]};
        end else if (!a[12]) begin
            chr_off = {2'd0, chr_low_reg, a[11:0]};
        end else begin
            chr_off = {2'd0, chr_high_reg, a[11:0]};
        end
    end

    // Serial loader
    assign shifted = {item.write_data[0], shift_reg[4:1]};

    always_comb begin
        shift_next    = shift_reg;
        control_next  = control_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        prg_bank_next = prg_bank_reg;
        if (item.func == FUNC_CPU_WR && a[15]) begin
            if (item.write_data[7]) begin
                shift_next   = SHIFT_EMPTY;
                control_next = control_reg | CONTROL_RST;
            end else if (shift_reg[0]) begin
                shift_next = SHIFT_EMPTY;
                unique case (a[14:13])
                    SEL_CONTROL:  control_next  = shifted;
                    SEL_CHR_LOW:  chr_low_next  = shifted;
                    SEL_CHR_HIGH: chr_high_next = shifted;
                    SEL_PRG:      prg_bank_next = shifted;
                    default: ;
                endcase
            end else begin
                shift_next = shifted;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= SHIFT_EMPTY;
            control_reg  <= CONTROL_RST;
            chr_low_reg  <= 5'd0;
            chr_high_reg <= 5'd0;
            prg_bank_reg <= 5'd0;
        end else if (step) begin
            shift_reg    <= shift_next;
            control_reg  <= control_next;
            chr_low_reg  <= chr_low_next;
            chr_high_reg <= chr_high_next;
            prg_bank_reg <= prg_bank_next;
        end
    end

    // Result fields
    always_comb begin
        res.target         = TGT_NONE;
        res.mapped_address = 19'd0;
        res.chr_in_range   = 1'b0;
        res.ram_rd         = 1'b0;
        if (in_wram) begin
            res.target = TGT_WRAM;
            res.ram_rd = (item.func == FUNC_CPU_RD);
        end else if (in_rom && item.func == FUNC_CPU_RD) begin
            res.target         = TGT_PRG;
            res.mapped_address = prg_off;
        end else if (in_chr) begin
            res.target         = TGT_CHR;
            res.mapped_address = chr_off;
            res.chr_in_range   = (chr_off < {1'b0, cfg.chr_bytes});
        end
        res.mirror_mode = control_next[1:0];
    end

    // Work RAM access
    assign wreq.rd_en = step && in_wram && (item.func == FUNC_CPU_RD);
    assign wreq.wr_en = step && in_wram && (item.func == FUNC_CPU_WR);
    assign wreq.addr  = wrem[WIN_AW-1:0];
    assign wreq.data  = item.write_data;

endmodule
`default_nettype wire

// File: design/serial_loaded_bank_mapper_unit.sv
// Serial-loaded bank mapper top level: input register, mapping, result register.
//
// One bus access per transaction; a new transaction is taken every cycle unless a full
// result register waits on m_ready or the work RAM sweep runs. The input register takes
// it on acceptance; the result register and the registered work RAM read port take it as
// it leaves the input register, and its result is valid from there. Mapper registers
// and the work RAM update in order as each transaction leaves the input register.
// After reset the work RAM is swept to zero, one byte per cycle; s_ready stays low
// during the sweep while APB writes are taken as usual.
`default_nettype none
module serial_loaded_bank_mapper_unit #(
    parameter int unsigned RAM_BYTES = slbm_pkg::RAM_BYTES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire slbm_pkg::slbm_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output slbm_pkg::slbm_out_t      m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import slbm_pkg::*;

    slbm_cfg_t      cfg;
    slbm_res_t      res;
    slbm_wram_req_t wreq;
    logic [7:0]     ram_rd_data;
    logic           clr_busy;

    logic      in_valid_reg;
    slbm_in_t  in_data_reg;
    logic      out_valid_reg;
    slbm_res_t out_res_reg;
    logic      adv;
    logic      s_fire;

    slbm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slbm_core #(.RAM_BYTES(RAM_BYTES)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (res),
        .wreq    (wreq)
    );

    slbm_wram #(.RAM_BYTES(RAM_BYTES)) u_wram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (wreq),
        .rd_data (ram_rd_data),
        .busy    (clr_busy)
    );

    // Pipeline handshake
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clr_busy && (!in_valid_reg || adv);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= s_fire || (in_valid_reg && !adv);
            out_valid_reg <= adv || (out_valid_reg && !m_ready);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_res_reg <= res;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_data.target         = out_res_reg.target;
    assign m_data.mapped_address = out_res_reg.mapped_address;
    assign m_data.ram_read_data  = out_res_reg.ram_rd ? ram_rd_data : 8'd0;
    assign m_data.chr_in_range   = out_res_reg.chr_in_range;
    assign m_data.mirror_mode    = out_res_reg.mirror_mode;

    // No transaction enters while the RAM sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input accepted during work RAM clear");

    // A full input stage only takes a new transaction while it drains
    a_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && in_valid_reg) |-> adv)
        else $error("input stage overwritten");

    // RAM data only appears on work RAM results
    a_rdata_wram: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ram_read_data != 8'd0) |-> (m_data.target == TGT_WRAM))
        else $error("ram data on non work RAM result");

    // Range flag only on pattern memory results
    a_range_chr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.chr_in_range) |-> (m_data.target == TGT_CHR))
        else $error("range flag on non pattern result");

endmodule
`default_nettype wire

// File: tb/sv/serial_loaded_bank_mapper_unit_tb.sv
// Self-checking testbench for the serial-loaded bank mapper unit.
module serial_loaded_bank_mapper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slbm_pkg::*;

    // Bus windows and bank geometry
    localparam logic [15:0] WRAM_BASE      = 16'h6000;
    localparam logic [15:0] ROM_BASE       = 16'h8000;
    localparam logic [15:0] ROM_HIGH_BASE  = 16'hC000;
    localparam logic [15:0] PPU_LIMIT      = 16'h2000;
    localparam logic [15:0] CHR_HIGH_BASE  = 16'h1000;
    localparam int unsigned PRG_BANK_SIZE  = 'h4000;
    localparam int unsigned CHR_BANK_SIZE  = 'h1000;
    localparam logic [4:0]  PRG_MODE_BITS  = 5'b01100;
    localparam logic [1:0]  PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0]  PRG_MODE_FIX_HIGH = 2'd3;
    localparam int          SINK_HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS       = 80;

    typedef struct {
        slbm_in_t  acc;
        bit        known;
        slbm_out_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    slbm_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    slbm_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mapper model state
    logic [4:0]  mdl_shift;
    logic [4:0]  mdl_ctrl;
    logic [4:0]  mdl_chr_lo;
    logic [4:0]  mdl_chr_hi;
    logic [4:0]  mdl_prg_bank;
    logic [7:0]  mdl_wram [RAM_BYTES_DEF];
    int unsigned cfg_prg_banks;
    int unsigned cfg_chr_bytes;

    slbm_out_t   pending_q [$];
    dir_row_t    dir_tab [$];
    bit          row_known;
    slbm_out_t   row_res;
    bit          no_idle;
    bit          sink_hold;
    int          fail_count;

    serial_loaded_bank_mapper_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mapping of one bus access; updates the model state like the block does
    function automatic slbm_out_t map_access(slbm_in_t acc);
        slbm_out_t   res;
        logic [12:0] idx;
        int unsigned bank;
        int unsigned off;
        logic [1:0]  mode;
        logic        full;
        res = '0;
        if (acc.func == FUNC_CPU_RD || acc.func == FUNC_CPU_WR) begin
            if (acc.bus_address >= WRAM_BASE && acc.bus_address < ROM_BASE) begin
                idx = 13'((int'(acc.bus_address) - int'(WRAM_BASE)) % RAM_BYTES_DEF);
                res.target = TGT_WRAM;
                if (acc.func == FUNC_CPU_RD) begin
                    res.ram_read_data = mdl_wram[idx];
                end else begin
                    mdl_wram[idx] = acc.write_data;
                end
            end else if (acc.bus_address >= ROM_BASE) begin
                if (acc.func == FUNC_CPU_RD) begin
                    // program ROM banking by PRG mode
                    bank = 32'(mdl_prg_bank[3:0]);
                    mode = mdl_ctrl[3:2];
                    if (mode != PRG_MODE_FIX_LOW && mode != PRG_MODE_FIX_HIGH) begin
                        off = (bank & 'hE) * PRG_BANK_SIZE + 32'(acc.bus_address[14:0]);
                    end else if (mode == PRG_MODE_FIX_LOW) begin
                        off = (acc.bus_address < ROM_HIGH_BASE)
                            ? 32'(acc.bus_address[13:0])
                            : bank * PRG_BANK_SIZE + 32'(acc.bus_address[13:0]);
                    end else begin
                        off = (acc.bus_address >= ROM_HIGH_BASE)
                            ? ((cfg_prg_banks - 1) & 'h1F) * PRG_BANK_SIZE
                              + 32'(acc.bus_address[13:0])
                            : bank * PRG_BANK_SIZE + 32'(acc.bus_address[13:0]);
                    end
                    res.target         = TGT_PRG;
                    res.mapped_address = 19'(off);
                end else if (acc.write_data[7]) begin
                    // reset write: empty shifter, force PRG mode 3
                    mdl_shift = SHIFT_EMPTY;
                    mdl_ctrl  = mdl_ctrl | PRG_MODE_BITS;
                end else begin
                    full      = mdl_shift[0];
                    mdl_shift = {acc.write_data[0], mdl_shift[4:1]};
                    if (full) begin
                        case (acc.bus_address[14:13])
                            SEL_CONTROL:  mdl_ctrl     = mdl_shift;
                            SEL_CHR_LOW:  mdl_chr_lo   = mdl_shift;
                            SEL_CHR_HIGH: mdl_chr_hi   = mdl_shift;
                            default:      mdl_prg_bank = mdl_shift;
                        endcase
                        mdl_shift = SHIFT_EMPTY;
                    end
                end
            end
        end else if (acc.bus_address < PPU_LIMIT) begin
            // pattern banking: one 8K bank or two 4K banks
            if (!mdl_ctrl[4]) begin
                off = 32'(mdl_chr_lo & 5'h1E) * CHR_BANK_SIZE + 32'(acc.bus_address[12:0]);
            end else if (acc.bus_address < CHR_HIGH_BASE) begin
                off = 32'(mdl_chr_lo) * CHR_BANK_SIZE + 32'(acc.bus_address[11:0]);
            end else begin
                off = 32'(mdl_chr_hi) * CHR_BANK_SIZE + 32'(acc.bus_address[11:0]);
            end
            res.target         = TGT_CHR;
            res.mapped_address = 19'(off);
            res.chr_in_range   = (off < cfg_chr_bytes);
        end
        res.mirror_mode = mdl_ctrl[1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic dir_row_t mk_ask(logic [1:0] func, logic [15:0] addr, logic [7:0] data);
        dir_row_t r;
        r.acc   = '{func, addr, data};
        r.known = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic dir_row_t mk_known(logic [1:0] func, logic [15:0] addr, logic [7:0] data,
                                          logic [1:0] tgt, logic [18:0] maddr,
                                          logic [7:0] rdata, int inr, int mir);
        dir_row_t r;
        r.acc   = '{func, addr, data};
        r.known = 1'b1;
        r.res   = '{tgt, maddr, rdata, 1'(inr), 2'(mir)};
        return r;
    endfunction

    // Result check, then record of the accepted input transaction
    always @(posedge aclk) begin : scoreboard
        slbm_out_t want;
        slbm_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transaction with no access pending");
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                check_field("target", 32'(want.target), 32'(m_data.target));
                check_field("mapped_address", 32'(want.mapped_address),
                            32'(m_data.mapped_address));
                check_field("ram_read_data", 32'(want.ram_read_data), 32'(m_data.ram_read_data));
                check_field("chr_in_range", 32'(want.chr_in_range), 32'(m_data.chr_in_range));
                check_field("mirror_mode", 32'(want.mirror_mode), 32'(m_data.mirror_mode));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            exp_res = map_access(s_data);
            if (row_known) exp_res = row_res;
            pending_q.push_back(exp_res);
        end
    end

    // Result sink: random wait before each transaction, one long hold-off on request
    initial begin : result_sink
        int wait_cyc;
        m_ready = 1'b0;
        forever begin
            wait_cyc = draw_wait();
            if (sink_hold) begin
                wait_cyc  = SINK_HOLD_CYCLES;
                sink_hold = 1'b0;
            end
            if (wait_cyc > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (wait_cyc - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_access(input slbm_in_t acc, input bit known, input slbm_out_t res);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data    <= acc;
        row_known <= known;
        row_res   <= res;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == CFG_PRG_BANKS) cfg_prg_banks = 32'(data[5:0]);
        else cfg_chr_bytes = 32'(data[17:0]);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_results_done();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random accesses, mostly register load sequences and mapped windows
    task automatic run_random(input int count);
        int          n;
        int          kind;
        int          b;
        logic [1:0]  sel;
        logic [12:0] low13;
        slbm_in_t    acc;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // five serial writes; now and then broken by a reset write
                sel = 2'($urandom_range(0, 3));
                for (b = 0; b < 5; b++) begin
                    low13           = 13'($urandom);
                    acc.func        = FUNC_CPU_WR;
                    acc.bus_address = {1'b1, sel, low13};
                    acc.write_data  = 8'($urandom) & 8'h7F;
                    if ($urandom_range(0, 19) == 0) acc.write_data[7] = 1'b1;
                    send_access(acc, 1'b0, '0);
                    n++;
                end
            end else begin
                low13          = 13'($urandom);
                acc.write_data = 8'($urandom);
                if (kind < 45) begin
                    acc.func        = FUNC_CPU_RD;
                    acc.bus_address = {1'b1, 2'($urandom), low13};
                end else if (kind < 65) begin
                    acc.func        = $urandom_range(0, 1) ? FUNC_PPU_RD : FUNC_PPU_WR;
                    acc.bus_address = {3'b000, low13};
                end else if (kind < 85) begin
                    // work RAM, often a small pool so reads hit earlier writes
                    if ($urandom_range(0, 1)) low13[12:4] = '0;
                    acc.func        = $urandom_range(0, 1) ? FUNC_CPU_RD : FUNC_CPU_WR;
                    acc.bus_address = {3'b011, low13};
                end else begin
                    acc.func        = 2'($urandom);
                    acc.bus_address = 16'($urandom);
                end
                send_access(acc, 1'b0, '0);
                n++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned banks, input int unsigned chr_size,
                             input int count);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_results_done();
        apb_write(CFG_PRG_BANKS, banks);
        apb_write(CFG_CHR_BYTES, chr_size);
        run_random(count);
    endtask

    initial begin : timeout
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : main
        int i;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        row_known  = 1'b0;
        row_res    = '0;
        no_idle    = 1'b0;
        sink_hold  = 1'b0;
        fail_count = 0;
        mdl_shift     = SHIFT_EMPTY;
        mdl_ctrl      = CONTROL_RST;
        mdl_chr_lo    = '0;
        mdl_chr_hi    = '0;
        mdl_prg_bank  = '0;
        cfg_prg_banks = 32'(PRG_BANKS_RST);
        cfg_chr_bytes = 32'(CHR_BYTES_RST);
        for (i = 0; i < RAM_BYTES_DEF; i++) mdl_wram[i] = '0;

        // Directed accesses at reset settings
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'h6000, 8'h00, TGT_WRAM, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'h0000, 8'hFF, TGT_NONE, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_WR, 16'h5FFF, 8'hFF, TGT_NONE, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'h8000, 8'h00, TGT_PRG, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'hFFFF, 8'h00, TGT_PRG, 19'h7FFF, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'hBFFF, 8'h00, TGT_PRG, 19'h3FFF, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_PPU_RD, 16'h0000, 8'h00, TGT_CHR, 19'h0, 8'h00, 1, 0));
        dir_tab.push_back(mk_known(FUNC_PPU_WR, 16'h1FFF, 8'hFF, TGT_CHR, 19'h1FFF, 8'h00, 1, 0));
        dir_tab.push_back(mk_known(FUNC_PPU_RD, 16'h2000, 8'h00, TGT_NONE, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_PPU_WR, 16'hFFFF, 8'hFF, TGT_NONE, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_WR, 16'h7FFF, 8'hFF, TGT_WRAM, 19'h0, 8'h00, 0, 0));
        dir_tab.push_back(mk_known(FUNC_CPU_RD, 16'h7FFF, 8'h00, TGT_WRAM, 19'h0, 8'hFF, 0, 0));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h6000, 8'h00));
        // load control with all ones: horizontal mirroring, PRG mode 3, 4K pattern banks
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h8000, 8'h01));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h9FFF, 8'h7F));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h8123, 8'h55));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h8000, 8'h03));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h9FFF, 8'h01));
        dir_tab.push_back(mk_ask(FUNC_PPU_RD, 16'h1000, 8'h00));
        // partial PRG load cut short by a reset write
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'hE000, 8'h01));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'hE000, 8'h00));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'hFFFF, 8'h80));
        dir_tab.push_back(mk_ask(FUNC_CPU_RD, 16'hC000, 8'h00));
        dir_tab.push_back(mk_ask(FUNC_CPU_WR, 16'h8000, 8'hFE));
        dir_tab.push_back(mk_ask(FUNC_CPU_RD, 16'h6000, 8'h00));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[k]) send_access(dir_tab[k].acc, dir_tab[k].known, dir_tab[k].res);

        // Random phases over configuration extremes
        run_phase(1, 0, PHASE_ITEMS);
        sink_hold = 1'b1;
        run_phase(32, 131072, PHASE_ITEMS);
        no_idle = 1'b1;
        run_phase(0, 262143, PHASE_ITEMS);
        no_idle = 1'b0;
        run_phase(63, $urandom_range(0, 131072), PHASE_ITEMS);
        run_phase($urandom_range(1, 32), $urandom_range(0, 131072), PHASE_ITEMS);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_results_done();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
